// File: hw/rtl/rss_pkg.sv
// shared types and constants for the rolling set of stacks
`default_nettype none

package rss_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'h7F;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_POP_AT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_ACCESS = 2'd1,
        S_RESULT = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic access;
        logic finish;
    } rss_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/rss_req_if.sv
// request channel: operation, push byte and plate index
`default_nettype none

interface rss_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] push_value;
    logic [3:0] plate_index;

    modport source (output valid, output operation, output push_value, output plate_index,
                    input ready);
    modport sink (input valid, input operation, input push_value, input plate_index,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rss_rsp_if.sv
// response channel: popped byte and status
`default_nettype none

interface rss_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pop_value;
    logic [1:0] status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink (input valid, input pop_value, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rolling_set_of_stacks_top.sv
// top level of the rolling set of stacks
//
//   channel  dir  beat contents
//   req      in   operation, push_value, plate_index
//   rsp      out  pop_value, status
//
// each item steps through capture with length memory read, store
// access with length write-back, then result load into the output register.
// the next beat is taken right after the result is loaded, while the
// result may still wait on rsp. a stalled rsp holds the block in its
// result cycle only once a previous result is still pending.
// reset clears the flags (so plate lengths read as zero) and the active plate at once.
`default_nettype none

module rolling_set_of_stacks_top
    import rss_pkg::*;
#(
    parameter int unsigned PLATE_DEPTH = 8,
    parameter int unsigned PLATE_COUNT = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rss_req_if.sink   req,
    rss_rsp_if.source rsp
);

    rss_cmd_t cmd;

    rss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    rss_datapath #(
        .PLATE_DEPTH (PLATE_DEPTH),
        .PLATE_COUNT (PLATE_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (req.operation),
        .push_value  (req.push_value),
        .plate_index (req.plate_index),
        .pop_value   (rsp.pop_value),
        .status      (rsp.status)
    );

endmodule

`default_nettype wire

// File: hw/rtl/rss_ctrl.sv
// sequencer for the rolling set of stacks: handshakes and datapath commands
`default_nettype none

module rss_ctrl
    import rss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output rss_cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_ACCESS;
                end
            end
            S_ACCESS: begin
                cmd.access = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                // wait until the output register is free
                if (!rsp_valid_reg || rsp_ready) begin
                    cmd.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid_reg)
        else $error("result not presented after finish");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
        else $error("new beat accepted while an item is in flight");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && rsp_valid_reg && !rsp_ready) |=> state_reg == S_RESULT)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: hw/rtl/rss_datapath.sv
// plate store, length memory, plate flags and result register
`default_nettype none

module rss_datapath
    import rss_pkg::*;
#(
    parameter int unsigned PLATE_DEPTH = 8,
    parameter int unsigned PLATE_COUNT = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rss_cmd_t            cmd,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [BYTE_W-1:0]   push_value,
    input  wire logic [INDEX_W-1:0]  plate_index,
    output logic [BYTE_W-1:0]        pop_value,
    output logic [STATUS_W-1:0]      status
);

    localparam int unsigned PI_W     = $clog2(PLATE_COUNT);
    localparam int unsigned LEN_W    = $clog2(PLATE_DEPTH + 1);
    localparam int unsigned SLOT_W   = (PLATE_DEPTH > 1) ? $clog2(PLATE_DEPTH) : 1;
    localparam int unsigned ADDR_W   = PI_W + SLOT_W;
    localparam int unsigned MEM_SIZE = PLATE_COUNT * (2 ** SLOT_W);

    logic [BYTE_W-1:0] store_mem [MEM_SIZE];
    logic [LEN_W-1:0]  len_mem   [PLATE_COUNT];

    logic [PLATE_COUNT-1:0] nonempty_reg, nonempty_next;
    logic [PLATE_COUNT-1:0] full_reg, full_next;
    logic [PLATE_COUNT-1:0] len_valid_reg, len_valid_next;
    logic [PI_W-1:0]        active_reg, active_next;

    logic                   do_wr_reg, do_rd_reg;
    logic [PI_W-1:0]        tgt_reg;
    logic [BYTE_W-1:0]      value_reg;
    status_t                status_reg;
    logic [LEN_W-1:0]       len_q_reg;
    logic [BYTE_W-1:0]      rd_q_reg;
    logic [BYTE_W-1:0]      pop_value_reg;
    status_t                status_out_reg;

    // decode of the incoming beat
    logic            top_found;
    logic [PI_W-1:0] top_plate;
    logic            dec_wr, dec_rd;
    logic [PI_W-1:0] dec_tgt;
    status_t         dec_status;
    logic            idx_ok;
    logic [PI_W-1:0] idx_plate;

    // access cycle
    logic [LEN_W-1:0]  len_cur;
    logic [LEN_W-1:0]  len_new;
    logic [ADDR_W-1:0] mem_addr;

    always_comb begin
        top_found = 1'b0;
        top_plate = '0;
        // plates above the active one are always empty, so the highest
        // nonempty plate is where a pop steps down to
        for (int i = 0; i < PLATE_COUNT; i++) begin
            if (nonempty_reg[i]) begin
                top_found = 1'b1;
                top_plate = PI_W'(i);
            end
        end
    end

    assign idx_ok    = (32'(plate_index) < PLATE_COUNT);
    assign idx_plate = PI_W'(plate_index);

    always_comb begin
        dec_wr      = 1'b0;
        dec_rd      = 1'b0;
        dec_tgt     = active_reg;
        dec_status  = ST_OK;
        active_next = active_reg;
        unique case (op_t'(operation))
            OP_PUSH: begin
                if (!full_reg[active_reg]) begin
                    dec_wr = 1'b1;
                end else if (active_reg != PI_W'(PLATE_COUNT - 1)) begin
                    dec_wr      = 1'b1;
                    dec_tgt     = active_reg + PI_W'(1);
                    active_next = active_reg + PI_W'(1);
                end else begin
                    dec_status = ST_FULL;
                end
            end
            OP_POP: begin
                if (top_found) begin
                    dec_rd      = 1'b1;
                    dec_tgt     = top_plate;
                    active_next = top_plate;
                end else begin
                    dec_status  = ST_EMPTY;
                    active_next = '0;
                end
            end
            OP_POP_AT: begin
                dec_tgt = idx_plate;
                if (idx_ok && nonempty_reg[idx_plate]) begin
                    dec_rd = 1'b1;
                end else begin
                    dec_status = ST_EMPTY;
                end
            end
            OP_NONE: begin
                dec_status = ST_OK;
            end
            default: dec_status = ST_OK;
        endcase
    end

    // lengths never written since reset read as zero
    assign len_cur  = len_valid_reg[tgt_reg] ? len_q_reg : '0;
    assign len_new  = do_wr_reg ? len_cur + LEN_W'(1) : len_cur - LEN_W'(1);
    assign mem_addr = {tgt_reg, do_wr_reg ? SLOT_W'(len_cur) : SLOT_W'(len_new)};

    always_comb begin
        nonempty_next  = nonempty_reg;
        full_next      = full_reg;
        len_valid_next = len_valid_reg;
        if (cmd.access && (do_wr_reg || do_rd_reg)) begin
            len_valid_next[tgt_reg] = 1'b1;
            nonempty_next[tgt_reg]  = (len_new != '0);
            full_next[tgt_reg]      = (len_new == LEN_W'(PLATE_DEPTH));
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            nonempty_reg  <= '0;
            full_reg      <= '0;
            len_valid_reg <= '0;
            active_reg    <= '0;
            do_wr_reg     <= 1'b0;
            do_rd_reg     <= 1'b0;
        end else begin
            nonempty_reg  <= nonempty_next;
            full_reg      <= full_next;
            len_valid_reg <= len_valid_next;
            if (cmd.capture) begin
                active_reg <= active_next;
                do_wr_reg  <= dec_wr;
                do_rd_reg  <= dec_rd;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            tgt_reg    <= dec_tgt;
            value_reg  <= push_value;
            status_reg <= dec_status;
        end
        if (cmd.finish) begin
            status_out_reg <= status_reg;
            if (status_reg == ST_EMPTY) begin
                pop_value_reg <= EMPTY_BYTE;
            end else if (do_rd_reg) begin
                pop_value_reg <= rd_q_reg;
            end else begin
                pop_value_reg <= '0;
            end
        end
    end

    // length memory: read at capture, written back in the access cycle
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            len_q_reg <= len_mem[dec_tgt];
        end
        if (cmd.access && (do_wr_reg || do_rd_reg)) begin
            len_mem[tgt_reg] <= len_new;
        end
    end

    // plate store
    always_ff @(posedge clk) begin
        if (cmd.access && do_wr_reg) begin
            store_mem[mem_addr] <= value_reg;
        end
        if (cmd.access && do_rd_reg) begin
            rd_q_reg <= store_mem[mem_addr];
        end
    end

    assign pop_value = pop_value_reg;
    assign status    = status_out_reg;

    a_full_is_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg & ~nonempty_reg) == '0)
        else $error("plate flagged full but empty");

    a_empty_above_active: assert property (@(posedge clk) disable iff (!rst_n)
        ((nonempty_reg >> active_reg) >> 1) == '0)
        else $error("nonempty plate above the active plate");

    a_push_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.access && do_wr_reg) |=> nonempty_reg[$past(tgt_reg)])
        else $error("pushed plate not marked nonempty");

endmodule

`default_nettype wire
